// ===== rtl/core/rlpm_pkg.sv =====
`default_nettype none
package rlpm_pkg;

  // default sizes handed to the top level
  localparam int MAX_RANGES_DEF  = 16;
  localparam int NUMBER_BITS_DEF = 16;

  // fixed field widths of the item channels
  localparam int QUERY_BITS     = 16;
  localparam int CHAR_BITS      = 8;
  localparam int KIND_BITS      = 2;
  localparam int COUNT_OUT_BITS = 5;
  localparam int DIGIT_BITS     = 4;

  // text constants
  localparam logic [CHAR_BITS-1:0] CHAR_DASH = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE = 8'h39;
  localparam int                   DEC_RADIX = 10;
  localparam int                   OPEN_STOP = 9999;

  // item kinds
  typedef enum logic [KIND_BITS-1:0] {
    KIND_TEXT  = 2'd0,
    KIND_END   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  // operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    ALU_IDLE  = 2'b00,
    ALU_MAC   = 2'b01,
    ALU_RANGE = 2'b10
  } alu_op_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_FIN    = 5'b00100,
    ST_WALK   = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  // parser phases
  typedef enum logic [2:0] {
    PH_START  = 3'b001,
    PH_FIRST  = 3'b010,
    PH_SECOND = 3'b100
  } phase_t;

endpackage
`default_nettype wire

// ===== rtl/core/rlpm_ram.sv =====
`default_nettype none
module rlpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                             wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output      logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/rlpm_alu.sv =====
`default_nettype none
module rlpm_alu #(
  parameter int NUMBER_BITS = rlpm_pkg::NUMBER_BITS_DEF,
  parameter int CMP_W       = 16
) (
  input  wire rlpm_pkg::alu_op_t                   op,
  input  wire logic [NUMBER_BITS-1:0]              mac_acc,
  input  wire logic [rlpm_pkg::DIGIT_BITS-1:0]     mac_digit,
  input  wire logic [CMP_W-1:0]                    cmp_lo,
  input  wire logic [CMP_W-1:0]                    cmp_x,
  input  wire logic [CMP_W-1:0]                    cmp_hi,
  output      logic [NUMBER_BITS-1:0]              mac_res,
  output      logic                                in_range
);

  localparam int WW = NUMBER_BITS + 4;

  logic [WW-1:0] wide;

  always_comb begin
    wide     = '0;
    mac_res  = '0;
    in_range = 1'b0;
    case (op)
      // acc * 10 + digit, saturating at the field maximum
      rlpm_pkg::ALU_MAC: begin
        wide = WW'(mac_acc) * WW'(rlpm_pkg::DEC_RADIX) + WW'(mac_digit);
        if (wide[WW-1:NUMBER_BITS] != '0) begin
          mac_res = '1;
        end else begin
          mac_res = wide[NUMBER_BITS-1:0];
        end
      end
      // lo <= x <= hi
      rlpm_pkg::ALU_RANGE: begin
        in_range = (cmp_lo <= cmp_x) && (cmp_x <= cmp_hi);
      end
      default: begin
        in_range = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/range_list_parse_and_match_core.sv =====
`default_nettype none
// channel   direction  handshake              payload
// in_       slave      in_tvalid / in_tready  tuser kind, tdata char + query number
// out_      master     out_tvalid / out_tready tdata included, range_error, ranges_stored
//
// one item at a time: in_tready is high only while the sequencer is idle
// text and end-of-list items give a result after decode, and for a finished range
// after one range check and table write through the shared unit
// a query walks the table one pair a cycle through the shared compare unit,
// stopping at the first hit; an empty table answers from decode without a walk
// the result holds on out_tdata until out_tready, then the sequencer returns to idle
// rst_n (synchronous) empties the table and returns the parser to range start
module range_list_parse_and_match_core #(
  parameter int MAX_RANGES  = rlpm_pkg::MAX_RANGES_DEF,
  parameter int NUMBER_BITS = rlpm_pkg::NUMBER_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // [7:0] text_char, [23:8] query_number
  input  wire logic [23:0] in_tdata,
  // [1:0] kind
  input  wire logic [1:0]  in_tuser,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // [0] included, [1] range_error, [6:2] ranges_stored, [7] zero
  output      logic [7:0]  out_tdata
);

  localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam int CMP_W = (NUMBER_BITS > rlpm_pkg::QUERY_BITS) ? NUMBER_BITS
                                                               : rlpm_pkg::QUERY_BITS;
  localparam logic [NUMBER_BITS-1:0] NUM_MAX = '1;
  localparam logic [NUMBER_BITS-1:0] OPEN_STOP_V =
    (64'(rlpm_pkg::OPEN_STOP) > ((64'd1 << NUMBER_BITS) - 64'd1)) ? NUM_MAX
                                                                   : NUMBER_BITS'(rlpm_pkg::OPEN_STOP);

  rlpm_pkg::state_t state_r, state_nxt;
  rlpm_pkg::phase_t phase_r, phase_nxt;
  rlpm_pkg::kind_t  kind_r, kind_nxt;

  logic [rlpm_pkg::CHAR_BITS-1:0]  ch_r, ch_nxt;
  logic [rlpm_pkg::QUERY_BITS-1:0] q_r, q_nxt;
  logic [NUMBER_BITS-1:0]          acc_r, acc_nxt;
  logic [NUMBER_BITS-1:0]          pend_r, pend_nxt;
  logic                            seen_r, seen_nxt;
  logic [NUMBER_BITS-1:0]          fin_start_r, fin_start_nxt;
  logic [NUMBER_BITS-1:0]          fin_stop_r, fin_stop_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [IDX_W-1:0]                chk_idx_r, chk_idx_nxt;
  logic                            inc_r, inc_nxt;
  logic                            err_r, err_nxt;

  // shared unit hookup
  rlpm_pkg::alu_op_t                 alu_op;
  logic [NUMBER_BITS-1:0]            alu_acc;
  logic [rlpm_pkg::DIGIT_BITS-1:0]   alu_digit;
  logic [CMP_W-1:0]                  alu_lo, alu_x, alu_hi;
  logic [NUMBER_BITS-1:0]            alu_mac;
  logic                              alu_in_range;

  // table port
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr, ram_raddr;
  logic [2*NUMBER_BITS-1:0]   ram_wdata, ram_rdata;

  logic                       is_digit;
  logic [rlpm_pkg::CHAR_BITS-1:0] dig_full;

  assign in_tready  = (state_r == rlpm_pkg::ST_IDLE);
  assign out_tvalid = (state_r == rlpm_pkg::ST_OUT);
  assign out_tdata  = {1'b0, rlpm_pkg::COUNT_OUT_BITS'(count_r), err_r, inc_r};

  assign is_digit  = (ch_r >= rlpm_pkg::CHAR_ZERO) && (ch_r <= rlpm_pkg::CHAR_NINE);
  assign dig_full  = ch_r - rlpm_pkg::CHAR_ZERO;
  assign alu_digit = dig_full[rlpm_pkg::DIGIT_BITS-1:0];
  assign ram_wdata = {fin_stop_r, fin_start_r};
  assign ram_waddr = count_r[IDX_W-1:0];

  rlpm_ram #(
    .WIDTH (2 * NUMBER_BITS),
    .DEPTH (MAX_RANGES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  rlpm_alu #(
    .NUMBER_BITS (NUMBER_BITS),
    .CMP_W       (CMP_W)
  ) u_alu (
    .op        (alu_op),
    .mac_acc   (alu_acc),
    .mac_digit (alu_digit),
    .cmp_lo    (alu_lo),
    .cmp_x     (alu_x),
    .cmp_hi    (alu_hi),
    .mac_res   (alu_mac),
    .in_range  (alu_in_range)
  );

  // sequencer and parser
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    ch_nxt        = ch_r;
    q_nxt         = q_r;
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    seen_nxt      = seen_r;
    fin_start_nxt = fin_start_r;
    fin_stop_nxt  = fin_stop_r;
    count_nxt     = count_r;
    chk_idx_nxt   = chk_idx_r;
    inc_nxt       = inc_r;
    err_nxt       = err_r;
    alu_op        = rlpm_pkg::ALU_IDLE;
    alu_acc       = acc_r;
    alu_lo        = '0;
    alu_x         = '0;
    alu_hi        = '0;
    ram_we        = 1'b0;
    ram_raddr     = '0;

    case (state_r)
      // take one item
      rlpm_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = rlpm_pkg::kind_t'(in_tuser);
          ch_nxt    = in_tdata[7:0];
          q_nxt     = in_tdata[23:8];
          inc_nxt   = 1'b0;
          err_nxt   = 1'b0;
          state_nxt = rlpm_pkg::ST_DECODE;
        end
      end

      // classify the item, accumulate digits, stage a finished range or start a query walk
      rlpm_pkg::ST_DECODE: begin
        state_nxt = rlpm_pkg::ST_OUT;
        case (kind_r)
          rlpm_pkg::KIND_TEXT: begin
            if (is_digit) begin
              alu_op  = rlpm_pkg::ALU_MAC;
              alu_acc = (phase_r == rlpm_pkg::PH_START) ? '0 : acc_r;
              acc_nxt = alu_mac;
              if (phase_r == rlpm_pkg::PH_START) begin
                phase_nxt = rlpm_pkg::PH_FIRST;
              end
              if (phase_r == rlpm_pkg::PH_SECOND) begin
                seen_nxt = 1'b1;
              end
            end else if (ch_r == rlpm_pkg::CHAR_DASH && phase_r != rlpm_pkg::PH_SECOND) begin
              pend_nxt  = (phase_r == rlpm_pkg::PH_FIRST) ? acc_r : '0;
              acc_nxt   = '0;
              seen_nxt  = 1'b0;
              phase_nxt = rlpm_pkg::PH_SECOND;
            end else begin
              // separator ends the range; at range start it stores 0-0
              state_nxt = rlpm_pkg::ST_FIN;
              if (phase_r == rlpm_pkg::PH_SECOND) begin
                fin_start_nxt = pend_r;
                fin_stop_nxt  = seen_r ? acc_r : OPEN_STOP_V;
              end else if (phase_r == rlpm_pkg::PH_FIRST) begin
                fin_start_nxt = acc_r;
                fin_stop_nxt  = acc_r;
              end else begin
                fin_start_nxt = '0;
                fin_stop_nxt  = '0;
              end
              phase_nxt = rlpm_pkg::PH_START;
              acc_nxt   = '0;
              pend_nxt  = '0;
              seen_nxt  = 1'b0;
            end
          end
          rlpm_pkg::KIND_END: begin
            if (phase_r == rlpm_pkg::PH_SECOND) begin
              fin_start_nxt = pend_r;
              fin_stop_nxt  = seen_r ? acc_r : OPEN_STOP_V;
              state_nxt     = rlpm_pkg::ST_FIN;
            end else if (phase_r == rlpm_pkg::PH_FIRST) begin
              fin_start_nxt = acc_r;
              fin_stop_nxt  = acc_r;
              state_nxt     = rlpm_pkg::ST_FIN;
            end
            phase_nxt = rlpm_pkg::PH_START;
            acc_nxt   = '0;
            pend_nxt  = '0;
            seen_nxt  = 1'b0;
          end
          rlpm_pkg::KIND_QUERY: begin
            if (count_r == '0) begin
              inc_nxt = 1'b1;
            end else begin
              ram_raddr   = '0;
              chk_idx_nxt = '0;
              state_nxt   = rlpm_pkg::ST_WALK;
            end
          end
          default: begin
            state_nxt = rlpm_pkg::ST_OUT;
          end
        endcase
      end

      // order check and table write of a finished range
      rlpm_pkg::ST_FIN: begin
        alu_op    = rlpm_pkg::ALU_RANGE;
        alu_lo    = CMP_W'(fin_start_r);
        alu_x     = CMP_W'(fin_stop_r);
        alu_hi    = CMP_W'(NUM_MAX);
        err_nxt   = !alu_in_range;
        if (alu_in_range && (count_r < CNT_W'(MAX_RANGES))) begin
          ram_we    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
        state_nxt = rlpm_pkg::ST_OUT;
      end

      // one stored pair per cycle against the query number
      rlpm_pkg::ST_WALK: begin
        alu_op = rlpm_pkg::ALU_RANGE;
        alu_lo = CMP_W'(ram_rdata[NUMBER_BITS-1:0]);
        alu_x  = CMP_W'(q_r);
        alu_hi = CMP_W'(ram_rdata[2*NUMBER_BITS-1:NUMBER_BITS]);
        if (alu_in_range) begin
          inc_nxt   = 1'b1;
          state_nxt = rlpm_pkg::ST_OUT;
        end else if (CNT_W'(chk_idx_r) == count_r - 1'b1) begin
          state_nxt = rlpm_pkg::ST_OUT;
        end else begin
          chk_idx_nxt = chk_idx_r + 1'b1;
          ram_raddr   = chk_idx_r + 1'b1;
        end
      end

      // hold the result until taken
      rlpm_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = rlpm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rlpm_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rlpm_pkg::ST_IDLE;
      phase_r   <= rlpm_pkg::PH_START;
      acc_r     <= '0;
      pend_r    <= '0;
      seen_r    <= 1'b0;
      count_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      pend_r    <= pend_nxt;
      seen_r    <= seen_nxt;
      count_r   <= count_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    ch_r        <= ch_nxt;
    q_r         <= q_nxt;
    fin_start_r <= fin_start_nxt;
    fin_stop_r  <= fin_stop_nxt;
    chk_idx_r   <= chk_idx_nxt;
    inc_r       <= inc_nxt;
    err_r       <= err_nxt;
  end

  // checks
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RANGES))
    else $error("pair count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |-> (count_r == $past(count_r) + 1'b1))
    else $error("pair count moved by more than one");

  a_empty_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (kind_r == rlpm_pkg::KIND_QUERY) && (count_r == '0) |-> inc_r)
    else $error("query on empty table not included");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && err_r |-> (kind_r == rlpm_pkg::KIND_TEXT) || (kind_r == rlpm_pkg::KIND_END))
    else $error("range error on an item that closes no range");

endmodule
`default_nettype wire
